// ----- sv/srg_pkg.sv -----
package srg_pkg;

  // draw commands
  typedef enum logic [1:0] {
    CMD_RAW   = 2'd0,
    CMD_RANGE = 2'd1,
    CMD_COIN  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } req_t;

  typedef struct packed {
    logic [63:0]        raw_word;
    logic signed [31:0] ranged_value;
    logic               coin_bit;
    logic               range_error;
  } rsp_t;

  // shared iterative unit
  localparam int unsigned DigitW   = 8;   // multiplier bits retired per step
  localparam int unsigned MulSteps = 64 / DigitW;
  localparam int unsigned ModSteps = 64;  // one dividend bit per step
  localparam int unsigned CntW     = $clog2(ModSteps);

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_MOD = 1'b1
  } op_e;

  typedef struct packed {
    logic        start;
    op_e         op;
    logic [63:0] opa;  // multiplicand / dividend
    logic [63:0] opb;  // multiplier / divisor (33 bits used)
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } unit_rsp_t;

endpackage

// ----- sv/srg_iter_unit.sv -----
// Iterative 64-bit unit: low half of a 64x64 product, one 8-bit digit a step,
// or 64-bit by 33-bit remainder, one restoring step a cycle.
module srg_iter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srg_pkg::unit_req_t req_i,
  output srg_pkg::unit_rsp_t rsp_o
);

  logic                     busy_q;
  logic                     done_q;
  logic [srg_pkg::CntW-1:0] cnt_q;
  srg_pkg::op_e             op_q;
  logic [63:0]              acc_q;
  logic [63:0]              a_q;
  logic [63:0]              b_q;

  logic [63+srg_pkg::DigitW:0] prod;
  logic [33:0]                 rem_sh;
  logic [33:0]                 divisor;
  logic [33:0]                 rem_sub;
  logic                        fits;
  logic                        last;

  assign prod    = a_q * b_q[srg_pkg::DigitW-1:0];
  assign rem_sh  = {acc_q[32:0], a_q[63]};
  assign divisor = {1'b0, b_q[32:0]};
  assign rem_sub = rem_sh - divisor;
  assign fits    = rem_sh >= divisor;
  assign last    = (op_q == srg_pkg::OP_MUL)
                 ? (cnt_q == srg_pkg::CntW'(srg_pkg::MulSteps - 1))
                 : (cnt_q == srg_pkg::CntW'(srg_pkg::ModSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      a_q   <= req_i.opa;
      b_q   <= req_i.opb;
      acc_q <= '0;
    end else if (busy_q) begin
      unique case (op_q)
        srg_pkg::OP_MUL: begin
          acc_q <= acc_q + prod[63:0];
          a_q   <= a_q << srg_pkg::DigitW;
          b_q   <= b_q >> srg_pkg::DigitW;
        end
        srg_pkg::OP_MOD: begin
          // remainder stays below the divisor, so 34 bits suffice
          acc_q <= fits ? {30'd0, rem_sub} : {30'd0, rem_sh};
          a_q   <= a_q << 1;
        end
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

// ----- sv/splitmix_range_generator.sv -----
// Channel   Dir  Handshake                  Payload
// in        in   in_valid_i / in_ready_o     in_req_i   (srg_pkg::req_t)
// out       out  out_valid_o / out_ready_i   out_rsp_o  (srg_pkg::rsp_t)
// cfg       in   cfg_valid_i / cfg_ready_o   cfg_seed_i (64-bit seed)
//
// Sequence: a raw or coin draw runs two multiplies on the shared unit, a range draw two
//   multiplies and then a modulo, and an inverted range or the unused command runs none.
//   The shared unit runs 8 steps per multiply, 64 per modulo.
// Reset clears the counter to the seed reset value (0). A seed write, taken only while idle,
//   reloads it. One request is worked on at a time; the next is taken once the sequencer is
//   idle, even while the previous result still waits in the output register.
module splitmix_range_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  srg_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output srg_pkg::rsp_t out_rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [63:0]   cfg_seed_i
);

  localparam logic [63:0] GoldenInc = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB   = 64'h94D049BB133111EB;
  localparam int unsigned ShiftA    = 30;
  localparam int unsigned ShiftB    = 27;
  localparam int unsigned ShiftC    = 31;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,  // first mixer multiply running
    ST_MUL2 = 5'b00100,  // second mixer multiply running
    ST_MOD  = 5'b01000,  // word mod span running
    ST_DONE = 5'b10000   // result ready, waiting for the output register
  } state_e;

  state_e              state_q, state_d;
  logic [63:0]         counter_q, counter_d;
  logic                is_range_q, is_range_d;
  logic signed [31:0]  low_q, low_d;
  logic [32:0]         span_q, span_d;
  logic [63:0]         word_q, word_d;
  logic signed [31:0]  ranged_q, ranged_d;
  logic                err_q, err_d;
  srg_pkg::rsp_t       out_q, out_d;
  logic                out_valid_q, out_valid_d;

  srg_pkg::unit_req_t  u_req;
  srg_pkg::unit_rsp_t  u_rsp;

  logic                accept;
  logic                bad_range;
  logic                draw;
  logic [63:0]         ctr_next;
  logic [63:0]         mixed;
  logic [31:0]         blo, bhi;

  srg_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .rsp_o  (u_rsp)
  );

  // seed writes only while idle; they win over requests
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign accept      = in_valid_i && in_ready_o;

  // biased compare: flipping the sign bit maps signed order onto unsigned
  assign blo       = in_req_i.range_low ^ 32'h8000_0000;
  assign bhi       = in_req_i.range_high ^ 32'h8000_0000;
  assign bad_range = blo > bhi;
  assign draw      = (in_req_i.command == srg_pkg::CMD_RAW)
                  || (in_req_i.command == srg_pkg::CMD_COIN)
                  || ((in_req_i.command == srg_pkg::CMD_RANGE) && !bad_range);
  assign ctr_next  = counter_q + GoldenInc;
  assign mixed     = u_rsp.result ^ (u_rsp.result >> ShiftC);

  always_comb begin
    state_d     = state_q;
    counter_d   = counter_q;
    is_range_d  = is_range_q;
    low_d       = low_q;
    span_d      = span_q;
    word_d      = word_q;
    ranged_d    = ranged_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    u_req       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          counter_d = cfg_seed_i;
        end else if (accept) begin
          is_range_d = (in_req_i.command == srg_pkg::CMD_RANGE);
          low_d      = in_req_i.range_low;
          span_d     = ({1'b0, bhi} - {1'b0, blo}) + 33'd1;
          err_d      = (in_req_i.command == srg_pkg::CMD_RANGE) && bad_range;
          word_d     = '0;
          ranged_d   = '0;
          if (draw) begin
            counter_d   = ctr_next;
            u_req.start = 1'b1;
            u_req.op    = srg_pkg::OP_MUL;
            u_req.opa   = ctr_next ^ (ctr_next >> ShiftA);
            u_req.opb   = MixMulA;
            state_d     = ST_MUL1;
          end else begin
            state_d = ST_DONE;  // inverted range or unused command: zeros
          end
        end
      end
      ST_MUL1: begin
        if (u_rsp.done) begin
          u_req.start = 1'b1;
          u_req.op    = srg_pkg::OP_MUL;
          u_req.opa   = u_rsp.result ^ (u_rsp.result >> ShiftB);
          u_req.opb   = MixMulB;
          state_d     = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (u_rsp.done) begin
          word_d = mixed;
          if (is_range_q) begin
            u_req.start = 1'b1;
            u_req.op    = srg_pkg::OP_MOD;
            u_req.opa   = mixed;
            u_req.opb   = {31'd0, span_q};
            state_d     = ST_MOD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MOD: begin
        if (u_rsp.done) begin
          // remainder is below 2^32, add with 32-bit wrap
          ranged_d = low_q + $signed(u_rsp.result[31:0]);
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.raw_word     = word_q;
          out_d.ranged_value = ranged_q;
          out_d.coin_bit     = word_q[0];
          out_d.range_error  = err_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      counter_q   <= '0;  // seed register resets to zero
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_range_q <= is_range_d;
    low_q      <= low_d;
    span_q     <= span_d;
    word_q     <= word_d;
    ranged_q   <= ranged_d;
    err_q      <= err_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // sequencer stays one-hot
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  // the unit only finishes while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_rsp.done |-> (state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_MOD))
    else $error("unit done outside a wait state");

  // a flagged range carries no drawn word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.range_error) |->
      (out_rsp_o.raw_word == 64'd0 && !out_rsp_o.coin_bit
       && out_rsp_o.ranged_value == 32'sd0))
    else $error("range error with nonzero result");

  // counter moves only on a seed write or an accepted draw
  a_counter_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(counter_q))
    else $error("counter changed mid-draw");

endmodule
